/* rtl/lbmc_pkg.sv */
package lbmc_pkg;

    localparam int DW = 32;
    localparam int FB = 24;
    localparam int NPOP = 9;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEP = DW / DIV_STAGES;
    localparam int LW = 2 * DW - FB + 1;

    typedef logic signed [DW-1:0] q_t;
    typedef q_t q9_t [NPOP];

    localparam q_t VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam q_t VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam q_t ZERO = '0;
    localparam q_t ONE  = q_t'(1) <<< FB;
    localparam q_t HALF = q_t'(1) <<< (FB - 1);
    localparam logic [2*DW:0] RND = (2*DW+1)'(1) << (FB - 1);
    localparam logic [LW-1:0] LIM = LW'(1) << (DW - 1);

    typedef enum logic [2:0] {
        REG_BETA  = 3'd0,
        REG_DT    = 3'd1,
        REG_INV   = 3'd2,
        REG_WREST = 3'd3,
        REG_WAXIS = 3'd4,
        REG_WDIAG = 3'd5
    } reg_idx_e;

    typedef struct packed {
        q_t beta;
        q_t dt;
        q_t inv;
        q_t wr;
        q_t wa;
        q_t wd;
    } cf_t;

    // long-division lane state
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] bits;
        logic [DW-1:0] quo;
        logic [DW-1:0] d;
        logic          neg;
        logic          ovf;
        logic          nonpos;
    } dvs_t;

    // node data carried beside the divider
    typedef struct {
        q9_t f;
        q_t  rho;
        q_t  fhx;
        q_t  fhy;
        q9_t fi;
        q_t  fscale;
    } sb_t;

    function automatic q_t qsat(input logic signed [DW:0] s);
        q_t r;
        if (s[DW] != s[DW-1]) begin
            r = s[DW] ? VMIN : VMAX;
        end else begin
            r = s[DW-1:0];
        end
        return r;
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        return qsat(s);
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        return qsat(s);
    endfunction

    function automatic logic [DW-1:0] qmag(input q_t a);
        logic [DW-1:0] m;
        m = a[DW-1] ? (~a + 1'b1) : a;
        return m;
    endfunction

    // full product, round half away from zero at FB, saturate
    function automatic q_t qmul(input q_t a, input q_t b);
        logic [DW-1:0]   ma;
        logic [DW-1:0]   mb;
        logic [2*DW-1:0] prod;
        logic [2*DW:0]   p;
        logic [LW-1:0]   lo;
        q_t              r;
        ma = qmag(a);
        mb = qmag(b);
        prod = {{DW{1'b0}}, ma} * {{DW{1'b0}}, mb};
        p = {1'b0, prod} + RND;
        lo = p[2*DW:FB];
        if (a[DW-1] ^ b[DW-1]) begin
            r = (lo >= LIM) ? VMIN : q_t'(~lo[DW-1:0] + 1'b1);
        end else begin
            r = (lo >= LIM) ? VMAX : q_t'(lo[DW-1:0]);
        end
        return r;
    endfunction

    function automatic int wclass(input int i);
        int c;
        if (i == 0) begin
            c = 0;
        end else if (i < 5) begin
            c = 1;
        end else begin
            c = 2;
        end
        return c;
    endfunction

endpackage

/* rtl/lbmc_front.sv */
module lbmc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  lbmc_pkg::q_t  in_pop [lbmc_pkg::NPOP],
    input  lbmc_pkg::q_t  in_fx,
    input  lbmc_pkg::q_t  in_fy,
    input  lbmc_pkg::cf_t cfg,
    output logic          out_valid,
    output lbmc_pkg::sb_t sb,
    output lbmc_pkg::dvs_t dx,
    output lbmc_pkg::dvs_t dy
);
    import lbmc_pkg::*;

    typedef struct {
        q9_t f;
        q_t  rho;
        q_t  mx;
        q_t  my;
        q_t  pfx;
        q_t  pfy;
        q9_t proj;
        q_t  winv [3];
        q_t  fscale;
    } f1_t;

    f1_t  s1_next, s1_reg;
    sb_t  sb_next, sb_reg;
    dvs_t dx_next, dx_reg, dy_next, dy_reg;
    logic v1_reg, v2_reg;

    function automatic dvs_t div_prep(input q_t mom, input q_t rho);
        dvs_t          s;
        logic [DW-1:0] m;
        m = qmag(mom);
        s.d = rho;
        s.neg = mom[DW-1];
        s.nonpos = rho[DW-1] || (rho == ZERO);
        s.ovf = (m >> (DW - FB)) >= rho;
        s.rem = m >> (DW - FB);
        s.bits = {m[DW-FB-1:0], {FB{1'b0}}};
        s.quo = '0;
        return s;
    endfunction

    // moments, force times dt, per-class weight scaling
    always_comb begin
        q_t t1, t2, t3, d1, r0, mx0, my0;
        for (int i = 0; i < NPOP; i++) s1_next.f[i] = in_pop[i];
        t1 = qadd(in_pop[1], in_pop[2]);
        mx0 = qsub(in_pop[1], in_pop[2]);
        t1 = qadd(t1, qadd(in_pop[3], in_pop[4]));
        my0 = qsub(in_pop[3], in_pop[4]);
        r0 = qadd(in_pop[0], t1);
        d1 = qadd(in_pop[5], in_pop[6]);
        t2 = qsub(in_pop[5], in_pop[6]);
        d1 = qadd(d1, qadd(in_pop[7], in_pop[8]));
        t3 = qsub(in_pop[7], in_pop[8]);
        s1_next.rho = qadd(r0, d1);
        s1_next.mx = qadd(mx0, qadd(t2, t3));
        s1_next.my = qadd(my0, qsub(t2, t3));
        s1_next.pfx = qmul(in_fx, cfg.dt);
        s1_next.pfy = qmul(in_fy, cfg.dt);
        s1_next.proj[0] = ZERO;
        s1_next.proj[1] = in_fx;
        s1_next.proj[2] = qsub(ZERO, in_fx);
        s1_next.proj[3] = in_fy;
        s1_next.proj[4] = qsub(ZERO, in_fy);
        s1_next.proj[5] = qadd(in_fx, in_fy);
        s1_next.proj[6] = qsub(ZERO, qadd(in_fx, in_fy));
        s1_next.proj[7] = qsub(in_fx, in_fy);
        s1_next.proj[8] = qsub(ZERO, qsub(in_fx, in_fy));
        s1_next.winv[0] = qmul(cfg.wr, cfg.inv);
        s1_next.winv[1] = qmul(cfg.wa, cfg.inv);
        s1_next.winv[2] = qmul(cfg.wd, cfg.inv);
        s1_next.fscale = qmul(qsub(ONE, cfg.beta), cfg.dt);
    end

    always_comb begin
        sb_next.f = s1_reg.f;
        sb_next.rho = s1_reg.rho;
        sb_next.fhx = qmul(s1_reg.pfx, HALF);
        sb_next.fhy = qmul(s1_reg.pfy, HALF);
        for (int i = 0; i < NPOP; i++) begin
            sb_next.fi[i] = qmul(s1_reg.winv[wclass(i)], s1_reg.proj[i]);
        end
        sb_next.fscale = s1_reg.fscale;
        dx_next = div_prep(s1_reg.mx, s1_reg.rho);
        dy_next = div_prep(s1_reg.my, s1_reg.rho);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            sb_reg <= sb_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    assign out_valid = v2_reg;
    assign sb = sb_reg;
    assign dx = dx_reg;
    assign dy = dy_reg;

endmodule

/* rtl/lbmc_div.sv */
module lbmc_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  lbmc_pkg::dvs_t din,
    output logic           out_valid,
    output lbmc_pkg::dvs_t dout
);
    import lbmc_pkg::*;

    dvs_t st_next [DIV_STAGES];
    dvs_t st_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] v_reg;

    // restoring division, DIV_STEP quotient bits per stage
    function automatic dvs_t div_step(input dvs_t si);
        dvs_t        s;
        logic [DW:0] r;
        s = si;
        for (int j = 0; j < DIV_STEP; j++) begin
            r = {s.rem, s.bits[DW-1]};
            s.bits = s.bits << 1;
            s.quo = s.quo << 1;
            if (r >= {1'b0, s.d}) begin
                r = r - {1'b0, s.d};
                s.quo[0] = 1'b1;
            end
            s.rem = r[DW-1:0];
        end
        return s;
    endfunction

    always_comb begin
        st_next[0] = div_step(din);
        for (int k = 1; k < DIV_STAGES; k++) st_next[k] = div_step(st_reg[k-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign dout = st_reg[DIV_STAGES-1];

endmodule

/* rtl/lbmc_back.sv */
module lbmc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  lbmc_pkg::sb_t  sb,
    input  lbmc_pkg::dvs_t dx,
    input  lbmc_pkg::dvs_t dy,
    input  lbmc_pkg::cf_t  cfg,
    output logic           out_valid,
    output lbmc_pkg::q_t   new_pop [lbmc_pkg::NPOP],
    output lbmc_pkg::q_t   density,
    output lbmc_pkg::q_t   vel_x,
    output lbmc_pkg::q_t   vel_y
);
    import lbmc_pkg::*;

    localparam int NB = 8;

    typedef struct {
        q9_t f;
        q_t  rho;
        q9_t frc;
        q_t  ux;
        q_t  uy;
        q_t  feqb [3];
        q_t  uxx;
        q_t  uyy;
        q_t  dir [4];
        q_t  sh;
        q_t  sq [4];
        q_t  hq [4];
        q_t  usq;
        q9_t fac;
        q9_t feq;
        q9_t relax;
        q9_t newp;
    } bk_t;

    bk_t bk_next [NB];
    bk_t bk_reg  [NB];
    logic [NB-1:0] v_reg;

    function automatic q_t vel_sat(input dvs_t s);
        q_t r;
        if (s.nonpos || s.ovf) begin
            r = s.neg ? VMIN : VMAX;
        end else if (s.neg) begin
            r = s.quo[DW-1] ? VMIN : q_t'(~s.quo + 1'b1);
        end else begin
            r = s.quo[DW-1] ? VMAX : q_t'(s.quo);
        end
        return r;
    endfunction

    // velocity shift, equilibrium base, force terms
    always_comb begin
        bk_next[0] = bk_reg[NB-1];
        bk_next[0].f = sb.f;
        bk_next[0].rho = sb.rho;
        bk_next[0].ux = qadd(vel_sat(dx), sb.fhx);
        bk_next[0].uy = qadd(vel_sat(dy), sb.fhy);
        bk_next[0].feqb[0] = qmul(sb.rho, cfg.wr);
        bk_next[0].feqb[1] = qmul(sb.rho, cfg.wa);
        bk_next[0].feqb[2] = qmul(sb.rho, cfg.wd);
        for (int i = 0; i < NPOP; i++) bk_next[0].frc[i] = qmul(sb.fscale, sb.fi[i]);
    end

    always_comb begin
        bk_next[1] = bk_reg[0];
        bk_next[1].uxx = qmul(bk_reg[0].ux, bk_reg[0].ux);
        bk_next[1].uyy = qmul(bk_reg[0].uy, bk_reg[0].uy);
        bk_next[1].dir[0] = qmul(cfg.inv, bk_reg[0].ux);
        bk_next[1].dir[1] = qmul(cfg.inv, bk_reg[0].uy);
    end

    always_comb begin
        bk_next[2] = bk_reg[1];
        bk_next[2].sh = qmul(qadd(bk_reg[1].uxx, bk_reg[1].uyy), HALF);
        bk_next[2].dir[2] = qadd(bk_reg[1].dir[0], bk_reg[1].dir[1]);
        bk_next[2].dir[3] = qsub(bk_reg[1].dir[0], bk_reg[1].dir[1]);
        bk_next[2].sq[0] = qmul(bk_reg[1].dir[0], bk_reg[1].dir[0]);
        bk_next[2].sq[1] = qmul(bk_reg[1].dir[1], bk_reg[1].dir[1]);
    end

    always_comb begin
        bk_next[3] = bk_reg[2];
        bk_next[3].usq = qmul(bk_reg[2].sh, cfg.inv);
        bk_next[3].sq[2] = qmul(bk_reg[2].dir[2], bk_reg[2].dir[2]);
        bk_next[3].sq[3] = qmul(bk_reg[2].dir[3], bk_reg[2].dir[3]);
        bk_next[3].hq[0] = qmul(bk_reg[2].sq[0], HALF);
        bk_next[3].hq[1] = qmul(bk_reg[2].sq[1], HALF);
    end

    // per-direction polynomial factors
    always_comb begin
        q_t h [4];
        bk_next[4] = bk_reg[3];
        h[0] = bk_reg[3].hq[0];
        h[1] = bk_reg[3].hq[1];
        h[2] = qmul(bk_reg[3].sq[2], HALF);
        h[3] = qmul(bk_reg[3].sq[3], HALF);
        bk_next[4].fac[0] = qsub(ONE, bk_reg[3].usq);
        for (int k = 0; k < 4; k++) begin
            bk_next[4].fac[1+2*k] = qsub(qadd(qadd(ONE, bk_reg[3].dir[k]), h[k]),
                                         bk_reg[3].usq);
            bk_next[4].fac[2+2*k] = qsub(qadd(qsub(ONE, bk_reg[3].dir[k]), h[k]),
                                         bk_reg[3].usq);
        end
    end

    always_comb begin
        bk_next[5] = bk_reg[4];
        for (int i = 0; i < NPOP; i++) begin
            bk_next[5].feq[i] = qmul(bk_reg[4].feqb[wclass(i)], bk_reg[4].fac[i]);
        end
    end

    always_comb begin
        q_t beta2;
        bk_next[6] = bk_reg[5];
        beta2 = qadd(cfg.beta, cfg.beta);
        for (int i = 0; i < NPOP; i++) begin
            bk_next[6].relax[i] = qmul(beta2, qsub(bk_reg[5].feq[i], bk_reg[5].f[i]));
        end
    end

    always_comb begin
        bk_next[7] = bk_reg[6];
        for (int i = 0; i < NPOP; i++) begin
            bk_next[7].newp[i] = qadd(bk_reg[6].f[i],
                                      qadd(bk_reg[6].relax[i], bk_reg[6].frc[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NB-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NB; k++) bk_reg[k] <= bk_next[k];
        end
    end

    assign out_valid = v_reg[NB-1];
    assign new_pop = bk_reg[NB-1].newp;
    assign density = bk_reg[NB-1].rho;
    assign vel_x = bk_reg[NB-1].ux;
    assign vel_y = bk_reg[NB-1].uy;

endmodule

/* rtl/lbm_d2q9_node_collision_unit.sv */
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: 9 populations then force x, y (32 b each)
// m_        out  m_tvalid/m_tready  m_tdata: 9 new populations, density, vel x, vel y
// cfg_      in   cfg_we             cfg_idx selects the register, cfg_wdata the value
//
// One node per cycle sustained while m_ is not stalled; the pipeline has 2 front stages, 4 divider
// stages at 8 quotient bits each and 8 equilibrium/relaxation stages.
// The node data delay line matches the divider depth; every stage holds one node.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// default register values. A stall on m_ freezes the whole pipeline and
// drops s_tready in the same cycle; nothing is lost or repeated.
module lbm_d2q9_node_collision_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pop_rest, pop_east, pop_west, pop_north, pop_south, pop_ne, pop_sw,
    // pop_se, pop_nw, force_x, force_y
    input  logic [351:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_rest, new_east, new_west, new_north, new_south, new_ne, new_sw,
    // new_se, new_nw, density, velocity_x, velocity_y
    output logic [383:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [30:0]  cfg_wdata
);
    import lbmc_pkg::*;

    logic [25:0] relax_beta_reg;
    logic [30:0] time_step_reg;
    logic [30:0] inv_theta0_reg;
    logic [24:0] weight_rest_reg;
    logic [24:0] weight_axis_reg;
    logic [24:0] weight_diag_reg;

    cf_t  cfg;
    logic en;
    q_t   in_pop [NPOP];
    q_t   in_fx, in_fy;

    logic fr_valid;
    sb_t  fr_sb;
    dvs_t fr_dx, fr_dy;

    sb_t  sb_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] sb_valid_reg;

    logic dvx_valid, dvy_valid;
    dvs_t dvx, dvy;

    q_t   new_pop [NPOP];
    q_t   density, vel_x, vel_y;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relax_beta_reg  <= 26'd16777216;
            time_step_reg   <= 31'd16777216;
            inv_theta0_reg  <= 31'd50331648;
            weight_rest_reg <= 25'd7456540;
            weight_axis_reg <= 25'd1864135;
            weight_diag_reg <= 25'd466034;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_BETA:  relax_beta_reg  <= cfg_wdata[25:0];
                REG_DT:    time_step_reg   <= cfg_wdata;
                REG_INV:   inv_theta0_reg  <= cfg_wdata;
                REG_WREST: weight_rest_reg <= cfg_wdata[24:0];
                REG_WAXIS: weight_axis_reg <= cfg_wdata[24:0];
                REG_WDIAG: weight_diag_reg <= cfg_wdata[24:0];
                default: begin
                end
            endcase
        end
    end

    // registers are unsigned and narrower than the data word: zero extend
    assign cfg.beta = q_t'(relax_beta_reg);
    assign cfg.dt   = q_t'(time_step_reg);
    assign cfg.inv  = q_t'(inv_theta0_reg);
    assign cfg.wr   = q_t'(weight_rest_reg);
    assign cfg.wa   = q_t'(weight_axis_reg);
    assign cfg.wd   = q_t'(weight_diag_reg);

    // advance the whole pipeline unless a finished result is held
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < NPOP; i++) in_pop[i] = s_tdata[DW*i +: DW];
    end
    assign in_fx = s_tdata[DW*NPOP +: DW];
    assign in_fy = s_tdata[DW*(NPOP+1) +: DW];

    lbmc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_pop    (in_pop),
        .in_fx     (in_fx),
        .in_fy     (in_fy),
        .cfg       (cfg),
        .out_valid (fr_valid),
        .sb        (fr_sb),
        .dx        (fr_dx),
        .dy        (fr_dy)
    );

    lbmc_div u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .din       (fr_dx),
        .out_valid (dvx_valid),
        .dout      (dvx)
    );

    lbmc_div u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .din       (fr_dy),
        .out_valid (dvy_valid),
        .dout      (dvy)
    );

    // hold the node data beside the divider, one tap per divider stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_valid_reg <= '0;
        end else if (en) begin
            sb_valid_reg <= {sb_valid_reg[DIV_STAGES-2:0], fr_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= fr_sb;
            for (int k = 1; k < DIV_STAGES; k++) sb_reg[k] <= sb_reg[k-1];
        end
    end

    lbmc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sb_valid_reg[DIV_STAGES-1]),
        .sb        (sb_reg[DIV_STAGES-1]),
        .dx        (dvx),
        .dy        (dvy),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .new_pop   (new_pop),
        .density   (density),
        .vel_x     (vel_x),
        .vel_y     (vel_y)
    );

    always_comb begin
        for (int i = 0; i < NPOP; i++) m_tdata[DW*i +: DW] = new_pop[i];
        m_tdata[DW*NPOP +: DW]     = density;
        m_tdata[DW*(NPOP+1) +: DW] = vel_x;
        m_tdata[DW*(NPOP+2) +: DW] = vel_y;
    end

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    a_div_align_x: assert property (@(posedge aclk) disable iff (!aresetn)
        dvx_valid == sb_valid_reg[DIV_STAGES-1])
        else $error("x divider lane out of step with node data");
    a_div_align_y: assert property (@(posedge aclk) disable iff (!aresetn)
        dvy_valid == dvx_valid)
        else $error("divider lanes out of step");
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(sb_valid_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
